[hw/rtl/tctd_pkg.sv]
// Shared constants, record type and state encodings for the contact delta tracker.
package tctd_pkg;

    // Finger slots tracked and coordinate resolution
    localparam int MAX_FINGERS = 5;
    localparam int COORD_BITS  = 16;

    // Coordinates arrive as 16-bit fields, so at most 16 bits are kept
    localparam int CW         = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int FW         = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;

    // Square root datapath: radicand width (even) and one step per result bit
    localparam int SQ_W       = 2 * CW + 2;
    localparam int ROOT_STEPS = CW + 1;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);

    // Record queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 120;

    // One record request handed from front to back
    typedef struct packed {
        logic [2:0]    finger_index;
        logic          tracked;
        logic          contact_down;
        logic [15:0]   start_x;
        logic [15:0]   start_y;
        logic [16:0]   delta_x;
        logic [16:0]   delta_y;
        logic [15:0]   start_stamp;
        logic [15:0]   elapsed;
        logic [CW-1:0] abs_x;
        logic [CW-1:0] abs_y;
        logic          record_last;
        logic          gesture_over;
    } rec_job_t;

    typedef enum logic [0:0] {
        F_IDLE,
        F_EMIT
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQX,
        B_SQY,
        B_ROOT,
        B_OUT
    } back_state_t;

endpackage

[hw/rtl/tctd_front.sv]
// Front end: takes contact slots, keeps finger state, queues one record request per finger.
module tctd_front
    import tctd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_conf,
    input  logic          in_tip,
    input  logic [7:0]    in_id,
    input  logic [15:0]   in_x,
    input  logic [15:0]   in_y,
    input  logic [15:0]   in_stamp,
    input  logic          in_last,
    output logic          push,
    output rec_job_t      job,
    input  logic          q_full
);

    front_state_t  state_reg, state_next;
    logic [FW-1:0] emit_idx_reg;
    logic          flag_reg    [MAX_FINGERS];
    logic [CW-1:0] org_x_reg   [MAX_FINGERS];
    logic [CW-1:0] org_y_reg   [MAX_FINGERS];
    logic [15:0]   org_st_reg  [MAX_FINGERS];
    logic [CW-1:0] cur_x_reg   [MAX_FINGERS];
    logic [CW-1:0] cur_y_reg   [MAX_FINGERS];
    logic          cur_tip_reg [MAX_FINGERS];
    logic          stopped_reg;
    logic          any_tip_reg;
    logic [15:0]   frame_stamp_reg;

    logic          in_fire;
    logic          slot_take;
    logic [FW-1:0] slot_sel;
    logic          emit_done;

    assign in_fire   = in_valid && in_ready;
    assign slot_take = in_fire && !stopped_reg && in_conf && (in_id < 8'(MAX_FINGERS));
    assign slot_sel  = in_id[FW-1:0];
    assign emit_done = push && (emit_idx_reg == FW'(MAX_FINGERS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_fire && in_last)
                    state_next = F_EMIT;
            end
            F_EMIT:
            begin
                if (emit_done)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            F_IDLE:  in_ready = 1'b1;
            F_EMIT:  push     = !q_full;
            default: ;
        endcase
    end

    // Control state and per-frame contact values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            emit_idx_reg <= '0;
            stopped_reg  <= 1'b0;
            any_tip_reg  <= 1'b0;
            for (int f = 0; f < MAX_FINGERS; f++)
            begin
                flag_reg[f]    <= 1'b0;
                cur_x_reg[f]   <= '0;
                cur_y_reg[f]   <= '0;
                cur_tip_reg[f] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((in_fire && in_last) || emit_done)
                emit_idx_reg <= '0;
            else if (push)
                emit_idx_reg <= emit_idx_reg + 1'b1;

            if (in_fire)
            begin
                if (in_tip)
                    any_tip_reg <= 1'b1;
                if (!stopped_reg && !in_conf)
                    stopped_reg <= 1'b1;
                for (int f = 0; f < MAX_FINGERS; f++)
                begin
                    if (slot_take && slot_sel == FW'(f))
                    begin
                        cur_x_reg[f]   <= in_x[CW-1:0];
                        cur_y_reg[f]   <= in_y[CW-1:0];
                        cur_tip_reg[f] <= in_tip;
                        flag_reg[f]    <= 1'b1;
                    end
                end
            end

            // End of frame: drop lifted fingers, clear all on a tipless frame
            if (emit_done)
            begin
                stopped_reg <= 1'b0;
                any_tip_reg <= 1'b0;
                for (int f = 0; f < MAX_FINGERS; f++)
                begin
                    flag_reg[f]    <= flag_reg[f] & cur_tip_reg[f] & any_tip_reg;
                    cur_x_reg[f]   <= '0;
                    cur_y_reg[f]   <= '0;
                    cur_tip_reg[f] <= 1'b0;
                end
            end
        end
    end

    // Start position and stamp latch on first sighting
    always_ff @(posedge clk)
    begin
        if (in_fire && in_last)
            frame_stamp_reg <= in_stamp;
        for (int f = 0; f < MAX_FINGERS; f++)
        begin
            if (slot_take && slot_sel == FW'(f) && !flag_reg[f])
            begin
                org_x_reg[f]  <= in_x[CW-1:0];
                org_y_reg[f]  <= in_y[CW-1:0];
                org_st_reg[f] <= in_stamp;
            end
        end
    end

    // Record request for the finger under emission
    always_comb
    begin
        logic [CW-1:0] cx, cy, ox, oy;
        logic [CW:0]   dxw, dyw;
        cx  = cur_x_reg[emit_idx_reg];
        cy  = cur_y_reg[emit_idx_reg];
        ox  = org_x_reg[emit_idx_reg];
        oy  = org_y_reg[emit_idx_reg];
        dxw = {1'b0, cx} - {1'b0, ox};
        dyw = {1'b0, cy} - {1'b0, oy};

        job              = '0;
        job.finger_index = 3'(emit_idx_reg);
        job.record_last  = (emit_idx_reg == FW'(MAX_FINGERS - 1));
        job.gesture_over = !any_tip_reg;
        if (flag_reg[emit_idx_reg])
        begin
            job.tracked      = 1'b1;
            job.contact_down = cur_tip_reg[emit_idx_reg];
            job.start_x      = 16'(ox);
            job.start_y      = 16'(oy);
            job.delta_x      = 17'(dxw);
            job.delta_y      = 17'(dyw);
            job.start_stamp  = org_st_reg[emit_idx_reg];
            job.elapsed      = frame_stamp_reg - org_st_reg[emit_idx_reg];
            job.abs_x        = (cx >= ox) ? (cx - ox) : (ox - cx);
            job.abs_y        = (cy >= oy) ? (cy - oy) : (oy - cy);
        end
    end

    // Closing slot starts emission from finger zero
    a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_last |=> state_reg == F_EMIT && emit_idx_reg == '0)
        else $error("frame close did not start record emission");

    // Frame flags are clear once the records are out
    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit_done |=> !any_tip_reg && !stopped_reg && state_reg == F_IDLE)
        else $error("per-frame state not cleared after emission");

endmodule

[hw/rtl/tctd_queue.sv]
// Short record queue between front and back.
module tctd_queue
    import tctd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rec_job_t job_in,
    output logic     full,
    input  logic     pop,
    output rec_job_t job_out,
    output logic     empty
);

    rec_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= job_in;
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("record queue read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop && full |=> 1'b0)
        else $error("record queue written while full");

endmodule

[hw/rtl/tctd_back.sv]
// Back end: squares the deltas, runs the bit-pair square root, holds the output record.
module tctd_back
    import tctd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    output logic                   pop,
    input  rec_job_t               job_in,
    input  logic                   empty,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_last,
    output logic                   out_user
);

    back_state_t            state_reg, state_next;
    rec_job_t               job_reg;
    logic [SQ_W-1:0]        rem_reg;
    logic [SQ_W-1:0]        root_reg;
    logic [SQ_W-1:0]        bit_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   out_user_reg;
    logic [16:0]            dist_reg;

    logic [CW-1:0]          mul_a;
    logic [2*CW-1:0]        mul_p;
    logic [SQ_W-1:0]        trial;
    logic                   take;
    logic [SQ_W-1:0]        root_step;
    logic                   root_done;
    logic                   load_out;

    // Shared squarer
    assign mul_a = (state_reg == B_SQX) ? job_reg.abs_x : job_reg.abs_y;
    assign mul_p = mul_a * mul_a;

    // One root bit per cycle
    assign trial     = root_reg + bit_reg;
    assign take      = (rem_reg >= trial);
    assign root_step = take ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign root_done = (step_reg == STEP_W'(ROOT_STEPS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = B_SQX;
            end
            B_SQX:  state_next = B_SQY;
            B_SQY:  state_next = B_ROOT;
            B_ROOT:
            begin
                if (root_done)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_ready)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop      = !empty;
            B_ROOT:  load_out = root_done;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_SQY)
                step_reg <= '0;
            else if (state_reg == B_ROOT)
                step_reg <= step_reg + 1'b1;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= job_in;
        unique case (state_reg)
            B_SQX:
            begin
                rem_reg <= SQ_W'(mul_p);
            end
            B_SQY:
            begin
                rem_reg  <= rem_reg + SQ_W'(mul_p);
                root_reg <= '0;
                bit_reg  <= {2'b01, {(SQ_W - 2){1'b0}}};
            end
            B_ROOT:
            begin
                if (take)
                    rem_reg <= rem_reg - trial;
                root_reg <= root_step;
                bit_reg  <= bit_reg >> 2;
            end
            default: ;
        endcase
        if (load_out)
        begin
            dist_reg     <= 17'(root_step);
            out_data_reg <= {17'(root_step), job_reg.elapsed, job_reg.start_stamp,
                             job_reg.delta_y, job_reg.delta_x, job_reg.start_y,
                             job_reg.start_x, job_reg.contact_down, job_reg.tracked,
                             job_reg.finger_index};
            out_last_reg <= job_reg.record_last;
            out_user_reg <= job_reg.gesture_over;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ROOT |-> step_reg < STEP_W'(ROOT_STEPS))
        else $error("root iteration ran past its last bit");

    // Euclidean length never exceeds the Manhattan length
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> 18'(dist_reg) <= 18'(job_reg.abs_x) + 18'(job_reg.abs_y))
        else $error("distance larger than sum of absolute deltas");

endmodule

[hw/rtl/touch_contact_delta_tracker_top.sv]
// Top level of the touchpad contact delta tracker.
//
// Slave stream: one contact slot per request, tlast marks the final slot of a
// frame. Master stream: after the final slot, one record per finger index
// (0 .. 4) in order, tlast on the record of the highest finger, tuser set when
// no slot of the frame showed a tip.
// Slots are taken while the front is idle. The closing slot moves the front
// into emission; it queues the five finger records into a two-entry queue at
// one per cycle while the queue is not full, and takes no slots until all five
// are queued. The back handles one record at a time: pop, squaring of the x
// and y deltas on the shared 16x16 multiplier, the bit-pair square root and
// the output register. The next record is popped only after the held one is
// taken.
// Reset clears finger tracking and frame state; start positions and the frame
// stamp are not cleared as they are only read for tracked fingers.
// When the master side stalls, the held record waits in the output register,
// the queue fills and then the front stops taking slots.
module touch_contact_delta_tracker_top
    import tctd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // slot_confidence, slot_tip, contact_id, pos_x, pos_y, scan_time, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // finger_index, tracked, contact_down, start_x, start_y, delta_x, delta_y,
    // start_stamp, elapsed, distance
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // gesture_over
    output logic                   m_axis_tuser
);

    rec_job_t push_job;
    rec_job_t pop_job;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    tctd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_conf  (s_axis_tdata[0]),
        .in_tip   (s_axis_tdata[1]),
        .in_id    (s_axis_tdata[9:2]),
        .in_x     (s_axis_tdata[25:10]),
        .in_y     (s_axis_tdata[41:26]),
        .in_stamp (s_axis_tdata[57:42]),
        .in_last  (s_axis_tlast),
        .push     (push),
        .job      (push_job),
        .q_full   (q_full)
    );

    tctd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (push_job),
        .full    (q_full),
        .pop     (pop),
        .job_out (pop_job),
        .empty   (q_empty)
    );

    tctd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .job_in    (pop_job),
        .empty     (q_empty),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

[tb/touch_contact_delta_tracker_top_test.sv]
// Self-checking stream testbench for the touchpad contact delta tracker.
`timescale 1ns / 100ps

module touch_contact_delta_tracker_top_test;
    import tctd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SLOTS   = 300;
    localparam int SETTLE_CYCLES  = 150;

    // One contact slot as it goes in
    typedef struct packed {
        logic        conf;
        logic        tip;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] stamp;
        logic        last;
    } contact_slot_t;

    // One finger record as it comes out
    typedef struct packed {
        logic [2:0]  finger_index;
        logic        tracked;
        logic        contact_down;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [16:0] delta_x;
        logic [16:0] delta_y;
        logic [15:0] start_stamp;
        logic [15:0] elapsed;
        logic [16:0] distance;
        logic        record_last;
        logic        gesture_over;
    } delta_rec_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    // Tracker mirror
    logic        trk_flag [MAX_FINGERS];
    logic [15:0] org_x    [MAX_FINGERS];
    logic [15:0] org_y    [MAX_FINGERS];
    logic [15:0] org_stamp[MAX_FINGERS];
    logic [15:0] cur_x    [MAX_FINGERS];
    logic [15:0] cur_y    [MAX_FINGERS];
    logic        cur_tip  [MAX_FINGERS];
    logic        frame_halted;
    logic        tip_in_frame;

    delta_rec_t  expected_records[$];
    int          error_count;
    int          records_checked;
    int          slots_sent;
    int          quiet_cycles;
    bit          send_burst;
    bit          recv_burst;
    logic [15:0] scan_clock;

    touch_contact_delta_tracker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mismatch reporting
    task automatic log_failure(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            log_failure($sformatf("record %0d %s: got %0h want %0h",
                                  records_checked, name, got, want));
    endtask

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    // Integer square root, one result bit per pass from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = 17; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic contact_slot_t mk_slot(input bit conf, input bit tip, input int id,
                                              input int x, input int y, input int stamp,
                                              input bit last);
        contact_slot_t s;
        s.conf  = conf;
        s.tip   = tip;
        s.id    = id[7:0];
        s.x     = x[15:0];
        s.y     = y[15:0];
        s.stamp = stamp[15:0];
        s.last  = last;
        return s;
    endfunction

    task automatic clear_tracker();
        int i;
        for (i = 0; i < MAX_FINGERS; i++)
        begin
            trk_flag[i]  = 1'b0;
            org_x[i]     = '0;
            org_y[i]     = '0;
            org_stamp[i] = '0;
            cur_x[i]     = '0;
            cur_y[i]     = '0;
            cur_tip[i]   = 1'b0;
        end
        frame_halted = 1'b0;
        tip_in_frame = 1'b0;
    endtask

    // Update tracking for one accepted slot; queue the records a frame end causes
    task automatic track_slot(input contact_slot_t s);
        delta_rec_t      r;
        logic [15:0]     ax;
        logic [15:0]     ay;
        logic            over;
        longint unsigned sq;
        int              i;
        if (s.tip)
            tip_in_frame = 1'b1;
        if (!frame_halted)
        begin
            if (!s.conf)
                frame_halted = 1'b1;
            else if (s.id < MAX_FINGERS)
            begin
                cur_x[s.id]   = s.x;
                cur_y[s.id]   = s.y;
                cur_tip[s.id] = s.tip;
                if (!trk_flag[s.id])
                begin
                    trk_flag[s.id]  = 1'b1;
                    org_x[s.id]     = s.x;
                    org_y[s.id]     = s.y;
                    org_stamp[s.id] = s.stamp;
                end
            end
        end
        if (s.last)
        begin
            over = !tip_in_frame;
            for (i = 0; i < MAX_FINGERS; i++)
            begin
                r              = '0;
                r.finger_index = 3'(i);
                r.record_last  = (i == MAX_FINGERS - 1);
                r.gesture_over = over;
                if (trk_flag[i])
                begin
                    ax = (cur_x[i] >= org_x[i]) ? cur_x[i] - org_x[i] : org_x[i] - cur_x[i];
                    ay = (cur_y[i] >= org_y[i]) ? cur_y[i] - org_y[i] : org_y[i] - cur_y[i];
                    sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
                    r.tracked      = 1'b1;
                    r.contact_down = cur_tip[i];
                    r.start_x      = org_x[i];
                    r.start_y      = org_y[i];
                    r.delta_x      = {1'b0, cur_x[i]} - {1'b0, org_x[i]};
                    r.delta_y      = {1'b0, cur_y[i]} - {1'b0, org_y[i]};
                    r.start_stamp  = org_stamp[i];
                    r.elapsed      = s.stamp - org_stamp[i];
                    r.distance     = 17'(floor_root(sq));
                end
                expected_records.push_back(r);
            end
            // lifted fingers drop out; a frame with no tip ends the gesture
            for (i = 0; i < MAX_FINGERS; i++)
            begin
                trk_flag[i] = trk_flag[i] & cur_tip[i];
                if (!trk_flag[i] || over)
                begin
                    trk_flag[i]  = 1'b0;
                    org_x[i]     = '0;
                    org_y[i]     = '0;
                    org_stamp[i] = '0;
                end
                cur_x[i]   = '0;
                cur_y[i]   = '0;
                cur_tip[i] = 1'b0;
            end
            frame_halted = 1'b0;
            tip_in_frame = 1'b0;
        end
    endtask

    // Send one slot request; returns at the falling edge after acceptance
    task automatic send_slot(input contact_slot_t s);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_burst = !send_burst;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {6'd0, s.stamp, s.y, s.x, s.id, s.tip, s.conf};
        s_axis_tlast  = s.last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_slot(s);
        slots_sent++;
        @(negedge clk);
    endtask

    task automatic hold_off();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
    endtask

    // Sender waits for every outstanding record
    task automatic drain_records();
        hold_off();
        while (expected_records.size() != 0)
            @(negedge clk);
    endtask

    // Record checker with random back-pressure
    initial
    begin
        delta_rec_t got;
        delta_rec_t want;
        int         stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            stall = draw_wait(recv_burst);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.finger_index = m_axis_tdata[2:0];
            got.tracked      = m_axis_tdata[3];
            got.contact_down = m_axis_tdata[4];
            got.start_x      = m_axis_tdata[20:5];
            got.start_y      = m_axis_tdata[36:21];
            got.delta_x      = m_axis_tdata[53:37];
            got.delta_y      = m_axis_tdata[70:54];
            got.start_stamp  = m_axis_tdata[86:71];
            got.elapsed      = m_axis_tdata[102:87];
            got.distance     = m_axis_tdata[119:103];
            got.record_last  = m_axis_tlast;
            got.gesture_over = m_axis_tuser;
            if (expected_records.size() == 0)
                log_failure($sformatf("unexpected record, finger %0d", got.finger_index));
            else
            begin
                want = expected_records.pop_front();
                compare_field("finger_index", got.finger_index, want.finger_index);
                compare_field("tracked",      got.tracked,      want.tracked);
                compare_field("contact_down", got.contact_down, want.contact_down);
                compare_field("start_x",      got.start_x,      want.start_x);
                compare_field("start_y",      got.start_y,      want.start_y);
                compare_field("delta_x",      got.delta_x,      want.delta_x);
                compare_field("delta_y",      got.delta_y,      want.delta_y);
                compare_field("start_stamp",  got.start_stamp,  want.start_stamp);
                compare_field("elapsed",      got.elapsed,      want.elapsed);
                compare_field("distance",     got.distance,     want.distance);
                compare_field("record_last",  got.record_last,  want.record_last);
                compare_field("gesture_over", got.gesture_over, want.gesture_over);
            end
            records_checked++;
            @(negedge clk);
        end
    end

    // Watchdog on cycles without any request moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // Frame straight after reset: nothing tracked, no tip
    task automatic test_fresh_state();
        send_slot(mk_slot(1, 0, 200, 16'h1234, 16'h5678, 10, 1));
    endtask

    // Corner coordinates, time stamp wrap, largest distance, unseen finger
    task automatic test_coordinate_extremes();
        send_slot(mk_slot(1, 1, 0, 0, 0, 16'hFFFF, 0));
        send_slot(mk_slot(1, 1, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        send_slot(mk_slot(1, 1, 0, 16'hFFFF, 16'hFFFF, 0, 0));
        send_slot(mk_slot(1, 1, 4, 0, 0, 0, 1));
        send_slot(mk_slot(1, 0, 0, 16'h8000, 16'h7FFF, 16'h4000, 1));
    endtask

    // First slot without confidence stops the rest of the frame
    task automatic test_confidence_stop();
        send_slot(mk_slot(1, 1, 1, 100, 200, 50, 0));
        send_slot(mk_slot(0, 1, 2, 300, 400, 50, 0));
        send_slot(mk_slot(1, 1, 3, 500, 600, 50, 0));
        send_slot(mk_slot(1, 1, 1, 900, 900, 60, 1));
    endtask

    // Out-of-range ids are ignored but their tip counts; tip-zero slot latches
    task automatic test_ignored_ids();
        send_slot(mk_slot(1, 1, 5, 11, 22, 70, 0));
        send_slot(mk_slot(1, 1, 255, 33, 44, 70, 0));
        send_slot(mk_slot(1, 0, 1, 950, 870, 80, 1));
    endtask

    // Same id twice: later slot sets current, start stays from the first
    task automatic test_repeat_id();
        send_slot(mk_slot(1, 1, 2, 1000, 1000, 300, 0));
        send_slot(mk_slot(1, 1, 2, 1500, 900, 310, 1));
    endtask

    // More slots than fingers in one frame
    task automatic test_long_frame();
        int i;
        for (i = 0; i < MAX_FINGERS; i++)
            send_slot(mk_slot(1, 1, i, 2000 + 100 * i, 3000 - 50 * i, 400, 0));
        send_slot(mk_slot(1, 1, 0, 2500, 2500, 405, 0));
        send_slot(mk_slot(1, 1, 3, 100, 60000, 410, 1));
    endtask

    // No tip anywhere in the frame ends the gesture
    task automatic test_gesture_over();
        send_slot(mk_slot(1, 0, 3, 777, 888, 500, 0));
        send_slot(mk_slot(0, 0, 0, 1, 2, 510, 1));
    endtask

    // Well-formed multi-finger gesture with some noise mixed in
    task automatic run_gesture();
        contact_slot_t frame_q[$];
        contact_slot_t tmp;
        logic [15:0]   fx[MAX_FINGERS];
        logic [15:0]   fy[MAX_FINGERS];
        bit            down[MAX_FINGERS];
        bit            any_down;
        bit            lift;
        int            frames;
        int            f;
        int            i;
        int            j;
        int            k;
        frames   = $urandom_range(2, 6);
        any_down = 1'b0;
        for (i = 0; i < MAX_FINGERS; i++)
        begin
            down[i]  = $urandom_range(0, 1);
            fx[i]    = 16'($urandom);
            fy[i]    = 16'($urandom);
            any_down = any_down | down[i];
        end
        if (!any_down)
            down[$urandom_range(0, MAX_FINGERS - 1)] = 1'b1;
        for (f = 0; f < frames; f++)
        begin
            frame_q.delete();
            if ($urandom_range(0, 15) == 0)
                scan_clock = 16'($urandom);
            else
                scan_clock = scan_clock + 16'($urandom_range(1, 400));
            for (i = 0; i < MAX_FINGERS; i++)
            begin
                if (!down[i] && $urandom_range(0, 9) == 0)
                begin
                    down[i] = 1'b1;
                    fx[i]   = 16'($urandom);
                    fy[i]   = 16'($urandom);
                end
                if (down[i])
                begin
                    fx[i] = fx[i] + 16'($urandom_range(0, 600)) - 16'd300;
                    fy[i] = fy[i] + 16'($urandom_range(0, 600)) - 16'd300;
                    tmp   = mk_slot(1, 1, i, fx[i], fy[i], scan_clock, 0);
                    if (f == frames - 1)
                        lift = $urandom_range(0, 1);
                    else
                        lift = ($urandom_range(0, 7) == 0);
                    if (lift)
                    begin
                        tmp.tip = 1'b0;
                        down[i] = 1'b0;
                    end
                    frame_q.push_back(tmp);
                end
            end
            if (frame_q.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                tmp       = frame_q[$urandom_range(0, frame_q.size() - 1)];
                tmp.x     = tmp.x + 16'd7;
                tmp.stamp = tmp.stamp + 16'd1;
                frame_q.push_back(tmp);
            end
            if ($urandom_range(0, 5) == 0)
                frame_q.push_back(mk_slot(1, $urandom_range(0, 1),
                                          $urandom_range(MAX_FINGERS, 255),
                                          $urandom, $urandom, scan_clock, 0));
            if ($urandom_range(0, 9) == 0)
                frame_q.push_back(mk_slot(0, $urandom_range(0, 1), $urandom_range(0, 255),
                                          $urandom, $urandom, scan_clock, 0));
            if (frame_q.size() == 0)
                frame_q.push_back(mk_slot(1, 0, $urandom_range(MAX_FINGERS, 255),
                                          $urandom, $urandom, scan_clock, 0));
            for (j = frame_q.size() - 1; j > 0; j--)
            begin
                k          = $urandom_range(0, j);
                tmp        = frame_q[j];
                frame_q[j] = frame_q[k];
                frame_q[k] = tmp;
            end
            tmp      = frame_q[frame_q.size() - 1];
            tmp.last = 1'b1;
            tmp.stamp = scan_clock;
            frame_q[frame_q.size() - 1] = tmp;
            foreach (frame_q[j])
                send_slot(frame_q[j]);
        end
        // often close with a frame that shows no tip
        if ($urandom_range(0, 1))
            send_slot(mk_slot(1, 0, $urandom_range(0, MAX_FINGERS - 1),
                              $urandom, $urandom, scan_clock + 16'd50, 1));
    endtask

    // Short frame of arbitrary slots
    task automatic run_noise_frame();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
            send_slot(mk_slot($urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 255), $urandom, $urandom, $urandom,
                              i == n - 1));
    endtask

    task automatic test_random_traffic();
        int  goal;
        bit  drained;
        goal    = slots_sent + RANDOM_SLOTS;
        drained = 1'b0;
        while (slots_sent < goal)
        begin
            if ($urandom_range(0, 9) < 7)
                run_gesture();
            else
                run_noise_frame();
            if (!drained && slots_sent >= goal - RANDOM_SLOTS / 2)
            begin
                drain_records();
                drained = 1'b1;
            end
        end
    endtask

    // Sequence of tests
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        error_count     = 0;
        records_checked = 0;
        slots_sent      = 0;
        quiet_cycles    = 0;
        send_burst      = 1'b0;
        recv_burst      = 1'b0;
        scan_clock      = 16'($urandom);
        clear_tracker();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fresh_state();
        test_coordinate_extremes();
        test_confidence_stop();
        test_ignored_ids();
        test_repeat_id();
        test_long_frame();
        test_gesture_over();
        test_random_traffic();

        drain_records();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
